FILE: hw/rtl/hssr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Half-step stepper ramp: shared types, constants and functions
// Item and result layouts, the half-step coil table and ramp helpers.
// ----------------------------------------------------------------------------
package hssr_pkg;

	localparam int unsigned PhaseW  = 3;
	localparam int unsigned PeriodW = 8;
	localparam int unsigned CountW  = 12;
	localparam int unsigned AngleW  = 9;
	localparam int unsigned CoilW   = 4;
	localparam int unsigned ProdW   = 16;

	localparam logic [CountW-1:0]  StepMax        = 12'hFFF;
	localparam logic [PeriodW-1:0] StartPeriodRst = 8'd35;
	localparam logic [6:0]         AngleScale     = 7'd91;
	localparam logic [PhaseW-1:0]  PhaseLeft      = 3'd0;
	localparam logic [PhaseW-1:0]  PhaseRight     = 3'd7;

	typedef enum logic {
		CMD_TICK  = 1'b0,
		CMD_START = 1'b1
	} cmd_t;

	typedef struct packed {
		cmd_t              command;
		logic              turn_right;
		logic [AngleW-1:0] angle_degrees;
	} item_t;

	typedef struct packed {
		logic [CoilW-1:0] coil_pattern;
		logic             busy;
		logic             done;
	} result_t;

	typedef struct packed {
		logic [PeriodW-1:0] period;
		logic [PeriodW-1:0] wait_len;
	} wait_t;

	function automatic logic [CoilW-1:0] coil_of(input logic [PhaseW-1:0] ph);
		logic [CoilW-1:0] c;
		case (ph)
			3'd0:    c = 4'd8;
			3'd1:    c = 4'd12;
			3'd2:    c = 4'd4;
			3'd3:    c = 4'd6;
			3'd4:    c = 4'd2;
			3'd5:    c = 4'd3;
			3'd6:    c = 4'd1;
			3'd7:    c = 4'd9;
			default: c = 4'd0;
		endcase
		return c;
	endfunction

	function automatic wait_t load_wait(input logic [PeriodW-1:0] p);
		wait_t w;
		if (p > PeriodW'(1)) begin
			w.period   = p - PeriodW'(1);
			w.wait_len = p - PeriodW'(1);
		end else begin
			w.period   = p;
			w.wait_len = PeriodW'(1);
		end
		return w;
	endfunction

	function automatic logic [CountW-1:0] angle_to_steps(input logic [AngleW-1:0] a);
		logic [ProdW-1:0]   prod;
		logic [ProdW-4:0]   shifted;
		prod    = ProdW'(a) * ProdW'(AngleScale);
		shifted = prod[ProdW-1:3];
		return (shifted > (ProdW-3)'(StepMax)) ? StepMax : shifted[CountW-1:0];
	endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/hssr_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Half-step stepper ramp: sequencer core
// Holds the rotation state and computes the next state and the result of one
// item in a single pass of combinational logic.
// ----------------------------------------------------------------------------
module hssr_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          fire,
	input  wire hssr_pkg::item_t               item,
	input  wire logic                          cfg_we,
	input  wire logic [hssr_pkg::PeriodW-1:0]  cfg_wdata,
	output hssr_pkg::result_t                  res
);

	logic [hssr_pkg::PeriodW-1:0] start_period_q, step_period_q, wait_left_q;
	logic [hssr_pkg::PhaseW-1:0]  phase_q;
	logic [hssr_pkg::CountW-1:0]  left_steps_q, right_steps_q, target_steps_q;
	logic                         going_right_q, running_q;

	logic [hssr_pkg::PeriodW-1:0] step_period_d, wait_left_d, wait_dec;
	logic [hssr_pkg::PhaseW-1:0]  phase_d;
	logic [hssr_pkg::CountW-1:0]  left_steps_d, right_steps_d, target_steps_d;
	logic [hssr_pkg::CountW-1:0]  cnt, cnt_inc;
	logic                         going_right_d, running_d, done_d;
	hssr_pkg::wait_t              lw_start, lw_step;

	always_comb begin
		step_period_d  = step_period_q;
		wait_left_d    = wait_left_q;
		phase_d        = phase_q;
		left_steps_d   = left_steps_q;
		right_steps_d  = right_steps_q;
		target_steps_d = target_steps_q;
		going_right_d  = going_right_q;
		running_d      = running_q;
		done_d         = 1'b0;
		lw_start       = hssr_pkg::load_wait(step_period_q);
		wait_dec       = (wait_left_q != '0) ? wait_left_q - hssr_pkg::PeriodW'(1) : '0;
		cnt            = going_right_q ? right_steps_q : left_steps_q;
		cnt_inc        = (cnt < hssr_pkg::StepMax) ? cnt + hssr_pkg::CountW'(1) : cnt;
		phase_d        = phase_q;
		lw_step        = hssr_pkg::load_wait(step_period_q);
		if (item.command == hssr_pkg::CMD_START) begin
			if (!running_q) begin
				target_steps_d = hssr_pkg::angle_to_steps(item.angle_degrees);
				going_right_d  = item.turn_right;
				if (item.turn_right) begin
					left_steps_d = '0;
					phase_d      = hssr_pkg::PhaseRight;
				end else begin
					right_steps_d = '0;
					phase_d       = hssr_pkg::PhaseLeft;
				end
				running_d     = 1'b1;
				step_period_d = lw_start.period;
				wait_left_d   = lw_start.wait_len;
			end
		end else if (running_q) begin
			wait_left_d = wait_dec;
			if (wait_dec == '0) begin
				if (going_right_q) begin
					right_steps_d = cnt_inc;
				end else begin
					left_steps_d = cnt_inc;
				end
				if (cnt_inc >= target_steps_q) begin
					step_period_d = start_period_q;
					running_d     = 1'b0;
					done_d        = 1'b1;
				end else begin
					phase_d       = going_right_q ? phase_q - hssr_pkg::PhaseW'(1)
						: phase_q + hssr_pkg::PhaseW'(1);
					step_period_d = lw_step.period;
					wait_left_d   = lw_step.wait_len;
				end
			end
		end
	end

	always_comb begin
		res.coil_pattern = running_d ? hssr_pkg::coil_of(phase_d) : '0;
		res.busy         = running_d;
		res.done         = done_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_period_q <= hssr_pkg::StartPeriodRst;
			step_period_q  <= hssr_pkg::StartPeriodRst;
			wait_left_q    <= '0;
			phase_q        <= '0;
			left_steps_q   <= '0;
			right_steps_q  <= '0;
			target_steps_q <= '0;
			going_right_q  <= 1'b0;
			running_q      <= 1'b0;
		end else begin
			if (fire) begin
				step_period_q  <= step_period_d;
				wait_left_q    <= wait_left_d;
				phase_q        <= phase_d;
				left_steps_q   <= left_steps_d;
				right_steps_q  <= right_steps_d;
				target_steps_q <= target_steps_d;
				going_right_q  <= going_right_d;
				running_q      <= running_d;
			end
			if (cfg_we) begin
				start_period_q <= cfg_wdata;
				if (!running_q && !fire) begin
					step_period_q <= cfg_wdata;
				end
			end
		end
	end

endmodule
`default_nettype wire

FILE: hw/rtl/half_step_stepper_ramp_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Half-step stepper ramp: top level
// Eight-phase half-step sequencer with an accelerating step period.
// ----------------------------------------------------------------------------
// Each input item is either a millisecond tick or a start command carrying a
// direction and an angle in degrees. Every item produces exactly one result:
// the coil pattern, a busy flag and a done pulse on the completing tick.
// The input channel registers the item, the core evaluates it in one pass
// and the result register holds it for the output channel.
// A result travels from the input register through the core to the result
// register, where a receiver stall holds it. Throughput is one item per cycle
// while the receiver does not stall; the sequencer state is updated once per item.
// When the receiver stalls, the result register holds its item and the input
// register fills; in_ready drops only when both are occupied.
// The start_period register is written through cfg_we and cfg_wdata and
// takes effect at once when idle with no item in the core, else when the
// running rotation ends. Reset clears the valid flags of both pipeline stages
// and the rotation state and loads a start period of 35 ticks.
// ----------------------------------------------------------------------------
module half_step_stepper_ramp_top (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire logic                                    in_valid,
	output logic                                         in_ready,
	input  wire logic                                    command,
	input  wire logic                                    turn_right,
	input  wire logic [hssr_pkg::AngleW-1:0]             angle_degrees,
	output logic                                         out_valid,
	input  wire logic                                    out_ready,
	output logic [hssr_pkg::CoilW-1:0]                   coil_pattern,
	output logic                                         busy_res,
	output logic                                         done_res,
	input  wire logic                                    cfg_we,
	input  wire logic [hssr_pkg::PeriodW-1:0]            cfg_wdata
);

	logic              valid_s1, valid_s2, adv, fire, in_fire;
	hssr_pkg::item_t   item_s1, in_item;
	hssr_pkg::result_t res, res_s2;

	assign in_item.command       = hssr_pkg::cmd_t'(command);
	assign in_item.turn_right    = turn_right;
	assign in_item.angle_degrees = angle_degrees;

	assign adv      = !valid_s2 || out_ready;
	assign fire     = valid_s1 && adv;
	assign in_ready = !valid_s1 || adv;
	assign in_fire  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_fire) begin
				valid_s1 <= 1'b1;
			end else if (fire) begin
				valid_s1 <= 1'b0;
			end
			if (fire) begin
				valid_s2 <= 1'b1;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_s1 <= in_item;
		end
		if (fire) begin
			res_s2 <= res;
		end
	end

	hssr_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.item      (item_s1),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.res       (res)
	);

	assign out_valid    = valid_s2;
	assign coil_pattern = res_s2.coil_pattern;
	assign busy_res     = res_s2.busy;
	assign done_res     = res_s2.done;

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(done_res && busy_res))
		else $error("done and busy reported together");

	a_idle_coils_off: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !busy_res) |-> (coil_pattern == '0))
		else $error("coils energised while idle");

	a_half_step_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && busy_res) |->
		($countones(coil_pattern) == 1 || $countones(coil_pattern) == 2))
		else $error("invalid half-step coil pattern");

	a_fire_loads_output: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> out_valid)
		else $error("processed item did not reach the result register");

endmodule
`default_nettype wire

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// Half-step stepper ramp: self-checking testbench
// Checks half_step_stepper_ramp_top against an in-bench model of the ramped
// half-step sequencer. The test drives rotations with random angles,
// directions and start periods, with ticks between them and ignored start
// commands during them, under random input gaps and output stalls.
// ----------------------------------------------------------------------------
module tb_top;
	import hssr_pkg::*;

	// Coil patterns of the eight half-step phases, phase 0 in the low nibble.
	localparam logic [31:0] HalfStepCoils = {4'd9, 4'd1, 4'd3, 4'd2, 4'd6, 4'd4, 4'd12, 4'd8};

	typedef struct packed {
		logic [PeriodW-1:0] start_period;
		logic [PeriodW-1:0] step_period;
		logic [PeriodW-1:0] wait_left;
		logic [PhaseW-1:0]  phase;
		logic [CountW-1:0]  left_steps;
		logic [CountW-1:0]  right_steps;
		logic [CountW-1:0]  target_steps;
		logic               going_right;
		logic               running;
	} ramp_state_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic              command = 1'b0;
	logic              turn_right = 1'b0;
	logic [AngleW-1:0] angle_degrees = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [CoilW-1:0]  coil_pattern;
	logic              busy_res;
	logic              done_res;
	logic              cfg_we = 1'b0;
	logic [PeriodW-1:0] cfg_wdata = '0;

	item_t       pending_items[$];
	result_t     expected_results[$];
	ramp_state_t sequencer_state;
	ramp_state_t plan_state;
	bit          item_taken = 1'b0;
	int unsigned accepted_items = 0;
	int unsigned planned_items = 0;
	int unsigned failures = 0;
	int unsigned burst_left = 0;
	int unsigned gap_left = 0;
	int unsigned hold_left = 0;
	int unsigned next_hold_at = 250;
	logic [9:0]  rx_cycle = '0;

	half_step_stepper_ramp_top uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.command      (command),
		.turn_right   (turn_right),
		.angle_degrees(angle_degrees),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.coil_pattern (coil_pattern),
		.busy_res     (busy_res),
		.done_res     (done_res),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata)
	);

	always #6 clk = ~clk;

	task automatic reset_sequencer(output ramp_state_t s);
		s = '0;
		s.start_period = StartPeriodRst;
		s.step_period  = StartPeriodRst;
	endtask

	task automatic apply_period(inout ramp_state_t s, input logic [PeriodW-1:0] p);
		s.start_period = p;
		if (!s.running) begin
			s.step_period = p;
		end
	endtask

	task automatic reload_wait(inout ramp_state_t s);
		if (s.step_period > 8'd1) begin
			s.step_period = s.step_period - 8'd1;
			s.wait_left   = s.step_period;
		end else begin
			s.wait_left = 8'd1;
		end
	endtask

	task automatic step_sequencer(inout ramp_state_t s, input item_t it, output result_t r);
		logic [15:0]       scaled;
		logic [CountW-1:0] count;
		r.done = 1'b0;
		if (it.command == CMD_START) begin
			if (!s.running) begin
				scaled = (16'(it.angle_degrees) * 16'(AngleScale)) >> 3;
				s.target_steps = (scaled > 16'(StepMax)) ? StepMax : scaled[CountW-1:0];
				s.going_right  = it.turn_right;
				if (it.turn_right) begin
					s.left_steps = '0;
					s.phase      = PhaseRight;
				end else begin
					s.right_steps = '0;
					s.phase       = PhaseLeft;
				end
				s.running = 1'b1;
				reload_wait(s);
			end
		end else if (s.running) begin
			if (s.wait_left != 8'd0) begin
				s.wait_left = s.wait_left - 8'd1;
			end
			if (s.wait_left == 8'd0) begin
				count = s.going_right ? s.right_steps : s.left_steps;
				if (count != StepMax) begin
					count = count + 12'd1;
				end
				if (s.going_right) begin
					s.right_steps = count;
				end else begin
					s.left_steps = count;
				end
				if (count >= s.target_steps) begin
					s.step_period = s.start_period;
					s.running     = 1'b0;
					r.done        = 1'b1;
				end else begin
					s.phase = s.going_right ? s.phase - 3'd1 : s.phase + 3'd1;
					reload_wait(s);
				end
			end
		end
		r.busy         = s.running;
		r.coil_pattern = s.running ? HalfStepCoils[s.phase*4 +: 4] : '0;
	endtask

	task automatic queue_item(input cmd_t cmd, input logic right, input logic [AngleW-1:0] angle);
		item_t   it;
		result_t unused;
		it.command       = cmd;
		it.turn_right    = right;
		it.angle_degrees = angle;
		if ((cmd == CMD_START) != plan_state.running) begin
			planned_items++;
		end
		pending_items.push_back(it);
		step_sequencer(plan_state, it, unused);
	endtask

	task automatic queue_tick();
		queue_item(CMD_TICK, 1'($urandom_range(0, 1)), 9'($urandom_range(0, 511)));
	endtask

	// Ticks until the rotation ends, with the odd start command that must be ignored.
	task automatic finish_rotation();
		while (plan_state.running) begin
			if ($urandom_range(0, 19) == 0) begin
				queue_item(CMD_START, 1'($urandom_range(0, 1)), 9'($urandom_range(0, 511)));
			end else begin
				queue_tick();
			end
		end
	endtask

	task automatic random_rotation();
		logic [AngleW-1:0] angle;
		int unsigned       pick;
		if ($urandom_range(0, 9) == 0) begin
			queue_tick();
		end
		pick = $urandom_range(0, 99);
		if (plan_state.start_period > 8'd40) begin
			angle = '0;
		end else if (plan_state.start_period > 8'd12) begin
			angle = (pick < 20) ? 9'd1 : 9'd0;
		end else if (pick < 60) begin
			angle = 9'($urandom_range(0, 2));
		end else if (pick < 90) begin
			angle = 9'($urandom_range(3, 8));
		end else begin
			angle = 9'($urandom_range(9, 25));
		end
		queue_item(CMD_START, 1'($urandom_range(0, 1)), angle);
		finish_rotation();
	endtask

	task automatic run_rotations(input int unsigned budget);
		int unsigned stop_at;
		stop_at = planned_items + budget;
		while (planned_items < stop_at) begin
			random_rotation();
		end
	endtask

	task automatic wait_quiet();
		while (pending_items.size() != 0 || in_valid || expected_results.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic write_period(input logic [PeriodW-1:0] p);
		wait_quiet();
		repeat (3) @(negedge clk);
		cfg_wdata <= p;
		cfg_we    <= 1'b1;
		apply_period(sequencer_state, p);
		apply_period(plan_state, p);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	always @(posedge clk) begin : accept_input
		item_t   it;
		result_t res;
		if (arst_n && in_valid && in_ready) begin
			it.command       = cmd_t'(command);
			it.turn_right    = turn_right;
			it.angle_degrees = angle_degrees;
			step_sequencer(sequencer_state, it, res);
			expected_results.push_back(res);
			accepted_items++;
			item_taken = 1'b1;
		end
	end

	always @(negedge clk) begin : sender
		logic  valid_next;
		item_t nxt;
		valid_next = in_valid;
		if (item_taken || !in_valid) begin
			item_taken = 1'b0;
			valid_next = 1'b0;
			if (gap_left != 0) begin
				gap_left--;
			end else if (arst_n && pending_items.size() != 0) begin
				nxt = pending_items.pop_front();
				command       <= nxt.command;
				turn_right    <= nxt.turn_right;
				angle_degrees <= nxt.angle_degrees;
				valid_next = 1'b1;
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 24);
					gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left--;
				end
			end
		end
		in_valid <= valid_next;
	end

	always @(negedge clk) begin : receiver
		rx_cycle <= rx_cycle + 10'd1;
		if (hold_left != 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (accepted_items >= next_hold_at) begin
			hold_left = $urandom_range(40, 80);
			next_hold_at += 600;
			out_ready <= 1'b0;
		end else begin
			case (rx_cycle[8:7])
				2'd0: out_ready <= 1'b1;
				2'd1: out_ready <= 1'($urandom_range(0, 1));
				2'd2: out_ready <= (rx_cycle[1:0] != 2'd3);
				default: out_ready <= ($urandom_range(0, 5) != 0);
			endcase
		end
	end

	always @(posedge clk) begin : check_result
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				failures++;
				if (failures <= 10) begin
					$display("Unexpected result: coil %h busy %b done %b",
						coil_pattern, busy_res, done_res);
				end
			end else begin
				want = expected_results.pop_front();
				if (want.coil_pattern !== coil_pattern || want.busy !== busy_res ||
					want.done !== done_res) begin
					failures++;
					if (failures <= 10) begin
						$display("Mismatch: expected coil %h busy %b done %b, got coil %h busy %b done %b",
							want.coil_pattern, want.busy, want.done,
							coil_pattern, busy_res, done_res);
					end
				end
			end
		end
	end

	initial begin
		#(12 * 400000);
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		reset_sequencer(sequencer_state);
		reset_sequencer(plan_state);
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Ticks while idle, then rotations at the reset period.
		queue_item(CMD_TICK, 1'b1, 9'd511);
		queue_item(CMD_TICK, 1'b0, 9'd0);
		run_rotations(120);

		write_period(8'd2);
		queue_item(CMD_START, 1'b0, 9'd0);
		finish_rotation();
		queue_item(CMD_START, 1'b1, 9'd1);
		queue_item(CMD_START, 1'b0, 9'd511);
		finish_rotation();
		// The right count is kept, so this rotation ends after one step.
		queue_item(CMD_START, 1'b1, 9'd1);
		finish_rotation();
		queue_item(CMD_START, 1'b0, 9'd2);
		finish_rotation();
		run_rotations(120);

		write_period(8'd255);
		run_rotations(1);
		write_period(8'd0);
		run_rotations(150);
		write_period(8'd1);
		run_rotations(150);

		while (planned_items < 1750) begin
			if ($urandom_range(0, 3) == 0) begin
				write_period(8'($urandom_range(11, 40)));
			end else begin
				write_period(8'($urandom_range(2, 10)));
			end
			run_rotations(120);
		end

		// An out-of-range angle saturates the target; the rotation is left running.
		write_period(8'($urandom_range(2, 8)));
		queue_item(CMD_START, 1'($urandom_range(0, 1)), 9'($urandom_range(361, 511)));
		repeat (80) queue_tick();

		wait_quiet();
		repeat (8) @(posedge clk);
		if (failures == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
